// ----- hw/rtl/psc_pkg.sv -----
// psc_pkg: shared types and constants for the pressure sensor compensation block
// no dependencies; imported by every psc module and by the top level
`default_nettype none

package psc_pkg;

    localparam int PSC_STAGES  = 6;
    localparam int PSC_ADDR_W  = 4;
    localparam int PSC_DATA_W  = 32;
    localparam int PSC_CAL_W   = 16;

    localparam logic [16:0] DT_BASE      = 17'd20224;
    localparam logic [16:0] D1_BASE      = 17'd7168;
    localparam logic [6:0]  C6_BIAS      = 7'd50;
    localparam logic [10:0] C4_BIAS      = 11'd512;
    localparam logic [24:0] TEMP_BASE    = 25'd204800;
    localparam logic [27:0] SENS_BASE    = 28'd25165824;
    localparam logic [49:0] PRES_BASE    = 50'd1342177280000;
    localparam int          TEMP_SHIFT   = 10;
    localparam int          PRES_SHIFT   = 29;

    typedef enum logic [1:0] {
        REG_CAL_ONE   = 2'd0,
        REG_CAL_TWO   = 2'd1,
        REG_CAL_THREE = 2'd2,
        REG_CAL_FOUR  = 2'd3
    } psc_reg_t;

    typedef struct packed {
        logic [15:0] raw_pressure;
        logic [15:0] raw_temperature;
    } psc_sample_t;

    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic [17:0]        pressure_tenths;
    } psc_result_t;

    typedef struct packed {
        logic [14:0] c1;
        logic [11:0] c2;
        logic [9:0]  c3;
        logic [9:0]  c4;
        logic [10:0] c5;
        logic [5:0]  c6;
    } psc_coef_t;

    typedef struct packed {
        logic signed [15:0] temp;
        logic signed [27:0] sens;
        logic signed [27:0] off;
        logic signed [16:0] d1m;
    } psc_mid_t;

endpackage

`default_nettype wire

// ----- hw/rtl/psc_cfg.sv -----
// psc_cfg: apb register file for the four calibration words and coefficient unpacking
// depends on psc_pkg
`default_nettype none

module psc_cfg
    import psc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PSC_ADDR_W-1:0] paddr,
    input  wire logic [PSC_DATA_W-1:0] pwdata,
    output logic      [PSC_DATA_W-1:0] prdata,
    output logic                       pready,
    output psc_coef_t                  coef
);

    logic [PSC_CAL_W-1:0] cal_one_reg;
    logic [PSC_CAL_W-1:0] cal_two_reg;
    logic [PSC_CAL_W-1:0] cal_three_reg;
    logic [PSC_CAL_W-1:0] cal_four_reg;
    logic                 wr_en;
    psc_reg_t             sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel    = psc_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_one_reg   <= '0;
            cal_two_reg   <= '0;
            cal_three_reg <= '0;
            cal_four_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_CAL_ONE:   cal_one_reg   <= pwdata[PSC_CAL_W-1:0];
                REG_CAL_TWO:   cal_two_reg   <= pwdata[PSC_CAL_W-1:0];
                REG_CAL_THREE: cal_three_reg <= pwdata[PSC_CAL_W-1:0];
                REG_CAL_FOUR:  cal_four_reg  <= pwdata[PSC_CAL_W-1:0];
                default:       cal_one_reg   <= cal_one_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_CAL_ONE:   prdata = {16'd0, cal_one_reg};
            REG_CAL_TWO:   prdata = {16'd0, cal_two_reg};
            REG_CAL_THREE: prdata = {16'd0, cal_three_reg};
            REG_CAL_FOUR:  prdata = {16'd0, cal_four_reg};
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        coef.c1 = cal_one_reg[15:1];
        coef.c2 = {cal_three_reg[5:0], cal_four_reg[5:0]};
        coef.c3 = cal_four_reg[15:6];
        coef.c4 = cal_three_reg[15:6];
        coef.c5 = {cal_one_reg[0], cal_two_reg[15:6]};
        coef.c6 = cal_two_reg[5:0];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/psc_ctrl.sv -----
// psc_ctrl: valid bits and per-stage load enables for the compensation pipeline
// depends on psc_pkg
`default_nettype none

module psc_ctrl
    import psc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  out_stall,
    output logic                       in_stall,
    output logic                       out_valid,
    output logic      [PSC_STAGES-1:0] en
);

    logic [PSC_STAGES-1:0] valid_reg;
    logic [PSC_STAGES-1:0] valid_next;
    logic [PSC_STAGES-1:0] ready;

    // a stage may load when it is empty or the stage after it moves on
    always_comb
    begin
        ready[PSC_STAGES-1] = !valid_reg[PSC_STAGES-1] || !out_stall;
        for (int i = PSC_STAGES - 2; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ready[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int i = 1; i < PSC_STAGES; i++)
        begin
            if (ready[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign en        = ready;
    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[PSC_STAGES-1];

endmodule

`default_nettype wire

// ----- hw/rtl/psc_front.sv -----
// psc_front: stages 0 to 2, dT, coefficient products, temperature and SENS/OFF sums
// depends on psc_pkg
`default_nettype none

module psc_front
    import psc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic [2:0]  en,
    input  wire psc_sample_t sample,
    input  wire psc_coef_t   coef,
    output psc_mid_t         mid
);

    // stage 0
    logic signed [16:0] dt_reg;
    logic signed [16:0] dt_next;
    logic signed [16:0] d1m0_reg;
    logic signed [16:0] d1m0_next;
    logic [16:0]        dt_base;

    // stage 1
    logic signed [24:0] tprod_reg;
    logic signed [24:0] tprod_next;
    logic signed [27:0] c3dt_reg;
    logic signed [27:0] c3dt_next;
    logic signed [27:0] c4dt_reg;
    logic signed [27:0] c4dt_next;
    logic signed [16:0] d1m1_reg;
    logic [6:0]         c6p;
    logic signed [10:0] c4m;

    // stage 2
    psc_mid_t           mid_reg;
    psc_mid_t           mid_next;
    logic signed [24:0] t10;
    logic signed [14:0] tq;

    always_comb
    begin
        dt_base   = {3'd0, coef.c5, 3'd0} + DT_BASE;
        dt_next   = $signed({1'b0, sample.raw_temperature} - dt_base);
        d1m0_next = $signed({1'b0, sample.raw_pressure} - D1_BASE);
    end

    always_comb
    begin
        c6p        = {1'b0, coef.c6} + C6_BIAS;
        c4m        = $signed({1'b0, coef.c4} - C4_BIAS);
        tprod_next = dt_reg * $signed({1'b0, c6p});
        c3dt_next  = dt_reg * $signed({1'b0, coef.c3});
        c4dt_next  = dt_reg * c4m;
    end

    // temperature truncates toward zero; the value always fits in 16 bits
    always_comb
    begin
        t10 = tprod_reg + $signed(TEMP_BASE);
        tq  = t10[24:TEMP_SHIFT];
        if (t10[24] && (t10[TEMP_SHIFT-1:0] != '0))
        begin
            tq = tq + 15'sd1;
        end
        mid_next.temp = {tq[14], tq};
        mid_next.sens = $signed({3'd0, coef.c1, 10'd0}) + c3dt_reg + $signed(SENS_BASE);
        mid_next.off  = $signed({2'd0, coef.c2, 14'd0}) + c4dt_reg;
        mid_next.d1m  = d1m1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dt_reg   <= dt_next;
            d1m0_reg <= d1m0_next;
        end
        if (en[1])
        begin
            tprod_reg <= tprod_next;
            c3dt_reg  <= c3dt_next;
            c4dt_reg  <= c4dt_next;
            d1m1_reg  <= d1m0_reg;
        end
        if (en[2])
        begin
            mid_reg <= mid_next;
        end
    end

    assign mid = mid_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/psc_back.sv -----
// psc_back: stages 3 to 5, SENS times D1 product, X assembly, pressure scaling and clamp
// depends on psc_pkg
`default_nettype none

module psc_back
    import psc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic [2:0]  en,
    input  wire psc_mid_t    mid,
    output psc_result_t      result
);

    // stage 3
    logic signed [44:0] prod_reg;
    logic signed [44:0] prod_next;
    logic signed [27:0] off3_reg;
    logic signed [15:0] temp3_reg;

    // stage 4
    logic signed [44:0] x_reg;
    logic signed [44:0] x_next;
    logic signed [15:0] temp4_reg;

    // stage 5
    psc_result_t        result_reg;
    psc_result_t        result_next;
    logic signed [49:0] xe;
    logic signed [49:0] pnum;
    logic [19:0]        pq;

    always_comb
    begin
        prod_next = mid.sens * mid.d1m;
        x_next    = prod_reg - $signed({{5{off3_reg[27]}}, off3_reg, 12'd0});
    end

    // negative numerator truncates to zero or below, so it clamps to zero
    always_comb
    begin
        xe   = {{5{x_reg[44]}}, x_reg};
        pnum = (xe <<< 3) + (xe <<< 1) + $signed(PRES_BASE);
        pq   = pnum[48:PRES_SHIFT];
        result_next.temperature_tenths = temp4_reg;
        if (pnum[49])
        begin
            result_next.pressure_tenths = '0;
        end
        else if (pq[19:18] != 2'd0)
        begin
            result_next.pressure_tenths = '1;
        end
        else
        begin
            result_next.pressure_tenths = pq[17:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg  <= prod_next;
            off3_reg  <= mid.off;
            temp3_reg <= mid.temp;
        end
        if (en[1])
        begin
            x_reg     <= x_next;
            temp4_reg <= temp3_reg;
        end
        if (en[2])
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pressure_sensor_compensation.sv -----
// pressure_sensor_compensation: top level of the barometric first-order compensation pipeline
// depends on psc_pkg, psc_cfg, psc_ctrl, psc_front, psc_back
//
//   channel   signals                              payload
//   sample    sample_valid, sample_stall, sample   raw_pressure, raw_temperature
//   result    result_valid, result_stall, result   temperature_tenths, pressure_tenths
//   config    apb psel/penable/pwrite/paddr/...    four 16-bit calibration words
//
// six register stages, one transfer per cycle on each channel while no stall holds it
// the stage-3 28x17 multiplier and the stage-1 dT multipliers set the stage depth
// reset clears the valid bits and the calibration words
// a stalled result holds the last stage; earlier stages keep loading until no bubble remains
`default_nettype none

module pressure_sensor_compensation
    import psc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PSC_ADDR_W-1:0] paddr,
    input  wire logic [PSC_DATA_W-1:0] pwdata,
    output logic      [PSC_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  sample_valid,
    output logic                       sample_stall,
    input  wire psc_sample_t           sample,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output psc_result_t                result
);

    psc_coef_t             coef;
    psc_mid_t              mid;
    logic [PSC_STAGES-1:0] en;

    psc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    psc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_valid),
        .out_stall (result_stall),
        .in_stall  (sample_stall),
        .out_valid (result_valid),
        .en        (en)
    );

    psc_front u_front (
        .clk    (clk),
        .en     (en[2:0]),
        .sample (sample),
        .coef   (coef),
        .mid    (mid)
    );

    psc_back u_back (
        .clk    (clk),
        .en     (en[5:3]),
        .mid    (mid),
        .result (result)
    );

endmodule

`default_nettype wire
